>>> hw/rtl/ray_triangle_intersect_assert.svh
// Assertion macros shared by the ray/triangle intersection RTL.
// Expects signals named clock and reset in the including module.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RTI_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rti: same-cycle check failed");

// next-cycle implication, checked outside reset
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rti: next-cycle check failed");

`endif

>>> hw/rtl/rti_pkg.sv
// Shared widths, constants and the front-to-back job type of the
// ray/triangle intersection block. No dependencies.
`timescale 1ns / 1ps

package rti_pkg;

   localparam int CW       = 21;              // packed coordinate width
   localparam int IN_W     = 63;              // packed vector port width
   localparam int EW       = CW + 1;          // edge / difference width
   localparam int PW       = 2 * EW + 1;      // cross product component width
   localparam int DW       = EW + PW + 2;     // dot product width
   localparam int LOW_W    = PW / 2;          // low slice of a split multiply
   localparam int EPS_W    = 20;
   localparam logic [EPS_W-1:0] EPS_RESET = 20'd1074;
   localparam int LIM_W    = 32;              // Q16.16 distance and limits
   localparam int SCALE    = 16;              // output fraction bits
   localparam int QB       = LIM_W - 1;       // quotient bits per divide
   localparam int BARY_W   = SCALE + 1;
   localparam int FIFO_AW  = 2;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;

   // classified item handed from the front to the back
   typedef struct packed {
      logic                    miss;
      logic                    tneg;
      logic                    ovf;
      logic [DW-1:0]           det;
      logic [DW-1:0]           mag;
      logic [DW-1:0]           un;
      logic [DW-1:0]           vn;
      logic signed [LIM_W-1:0] near_lim;
      logic signed [LIM_W-1:0] far_lim;
   } job_type;

endpackage

>>> hw/rtl/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rti_pkg. Gives floor((num << SCALE) / den) when below 2^QB.
`timescale 1ns / 1ps

module rti_div (
   input  logic                     clock,
   input  logic                     en,
   input  logic [rti_pkg::DW-1:0]   num,
   input  logic [rti_pkg::DW-1:0]   den,
   output logic [rti_pkg::QB-1:0]   quo,
   output logic                     rem_nz
);

   localparam int DW  = rti_pkg::DW;
   localparam int QB  = rti_pkg::QB;
   localparam int PRE = QB - rti_pkg::SCALE;

   logic [DW-1:0] rem_ff [QB];
   logic [DW-1:0] rem_in [QB];
   logic [QB-1:0] low_ff [QB];
   logic [QB-1:0] low_in [QB];
   logic [QB-1:0] quo_ff [QB];
   logic [QB-1:0] quo_in [QB];
   logic [DW-1:0] den_ff [QB];
   logic [DW-1:0] den_in [QB];

   // one compare/subtract per stage
   always_comb begin
      logic [DW-1:0] pr;
      logic [QB-1:0] pl;
      logic [QB-1:0] pq;
      logic [DW-1:0] pd;
      logic [DW:0]   cat;
      logic          ge;
      for (int k = 0; k < QB; k++) begin
         if (k == 0) begin
            pr = DW'(num >> PRE);
            pl = {num[PRE-1:0], {rti_pkg::SCALE{1'b0}}};
            pq = '0;
            pd = den;
         end else begin
            pr = rem_ff[k-1];
            pl = low_ff[k-1];
            pq = quo_ff[k-1];
            pd = den_ff[k-1];
         end
         cat       = {pr, pl[QB-1]};
         ge        = cat >= {1'b0, pd};
         rem_in[k] = ge ? DW'(cat - {1'b0, pd}) : cat[DW-1:0];
         low_in[k] = {pl[QB-2:0], 1'b0};
         quo_in[k] = {pq[QB-2:0], ge};
         den_in[k] = pd;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QB; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign quo    = quo_ff[QB-1];
   assign rem_nz = rem_ff[QB-1] != '0;

endmodule

>>> hw/rtl/rti_front.sv
// Front pipeline: unpack, cross and dot products, sign fix and hit
// classification. Holds the epsilon register. Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rti_pkg::EPS_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rti_pkg::IN_W-1:0]          req_ray_origin,
   input  logic [rti_pkg::IN_W-1:0]          req_ray_direction,
   input  logic [rti_pkg::IN_W-1:0]          req_vertex_a,
   input  logic [rti_pkg::IN_W-1:0]          req_vertex_b,
   input  logic [rti_pkg::IN_W-1:0]          req_vertex_c,
   input  logic signed [rti_pkg::LIM_W-1:0]  req_near_limit,
   input  logic signed [rti_pkg::LIM_W-1:0]  req_far_limit,
   input  logic                              fifo_full,
   output logic                              push,
   output rti_pkg::job_type                  job
);

   localparam int CW   = rti_pkg::CW;
   localparam int EW   = rti_pkg::EW;
   localparam int PW   = rti_pkg::PW;
   localparam int DW   = rti_pkg::DW;
   localparam int LW   = rti_pkg::LOW_W;
   localparam int HW   = PW - LW;
   localparam int PHW  = EW + HW;
   localparam int PLW  = EW + LW + 1;
   localparam int NSTG = 7;
   localparam int SH   = rti_pkg::QB - rti_pkg::SCALE;

   function automatic logic signed [EW-1:0] coord(
      input logic [rti_pkg::IN_W-1:0] p, input int k);
      logic [CW-1:0] c;
      c = p[k*CW +: CW];
      return {c[CW-1], c};
   endfunction

   function automatic int nx(input int k);
      return (k == 2) ? 0 : k + 1;
   endfunction

   logic                     fe_en;
   logic [rti_pkg::EPS_W-1:0] eps_ff;
   logic [NSTG-1:0]          vld_ff;
   logic [NSTG-1:0]          vld_in;
   logic signed [rti_pkg::LIM_W-1:0] near_ff [NSTG-1];
   logic signed [rti_pkg::LIM_W-1:0] far_ff  [NSTG-1];

   logic signed [EW-1:0]   d1_ff [3], t1_ff [3], e11_ff [3], e21_ff [3];
   logic signed [EW-1:0]   d2_ff [3], t2_ff [3], e12_ff [3], e22_ff [3];
   logic signed [EW-1:0]   d3_ff [3], t3_ff [3], e13_ff [3], e23_ff [3];
   logic signed [2*EW-1:0] mp_ff [6], mq_ff [6];
   logic signed [PW-1:0]   p_ff [3], q_ff [3];
   logic signed [EW-1:0]   opa [4][3];
   logic signed [PW-1:0]   opb [4][3];
   logic signed [PHW-1:0]  phi_ff [4][3];
   logic signed [PLW-1:0]  plo_ff [4][3];
   logic signed [DW-1:0]   dot_in [4];
   logic signed [DW-1:0]   dot_ff [4];
   logic [DW-1:0]          nrm_ff [4];
   logic                   zero_ff;
   rti_pkg::job_type       job_in;
   rti_pkg::job_type       job_ff;

   assign fe_en     = !fifo_full;
   assign req_ready = fe_en;
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};
   assign push      = vld_ff[NSTG-1] && fe_en;
   assign job       = job_ff;

   // epsilon register
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= rti_pkg::EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // beat valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (fe_en) begin
         vld_ff <= vld_in;
      end
   end

   // dot product operands: det = e1.p, u = t.p, v = d.q, t = e2.q
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         opa[0][k] = e13_ff[k];  opb[0][k] = p_ff[k];
         opa[1][k] = t3_ff[k];   opb[1][k] = p_ff[k];
         opa[2][k] = d3_ff[k];   opb[2][k] = q_ff[k];
         opa[3][k] = e23_ff[k];  opb[3][k] = q_ff[k];
      end
   end

   // partial product sums
   always_comb begin
      logic signed [DW-1:0] acc;
      for (int i = 0; i < 4; i++) begin
         acc = '0;
         for (int k = 0; k < 3; k++) begin
            acc = acc + (DW'(phi_ff[i][k]) <<< LW) + DW'(plo_ff[i][k]);
         end
         dot_in[i] = acc;
      end
   end

   // classification
   always_comb begin
      logic [DW-1:0] det;
      logic [DW-1:0] un;
      logic [DW-1:0] vn;
      logic [DW-1:0] tn;
      logic [DW:0]   uv;
      det = nrm_ff[0];
      un  = nrm_ff[1];
      vn  = nrm_ff[2];
      tn  = nrm_ff[3];
      uv  = {1'b0, un} + {1'b0, vn};
      job_in.miss = zero_ff || (det < DW'(eps_ff)) || un[DW-1] || (un > det)
                    || vn[DW-1] || (uv > {1'b0, det});
      job_in.tneg = tn[DW-1];
      job_in.mag  = tn[DW-1] ? DW'(-tn) : tn;
      job_in.ovf  = (DW+SH)'(job_in.mag) >= {det, {SH{1'b0}}};
      job_in.det  = det;
      job_in.un   = un;
      job_in.vn   = vn;
      job_in.near_lim = near_ff[NSTG-2];
      job_in.far_lim  = far_ff[NSTG-2];
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (fe_en) begin
         near_ff[0] <= req_near_limit;
         far_ff[0]  <= req_far_limit;
         for (int k = 1; k < NSTG-1; k++) begin
            near_ff[k] <= near_ff[k-1];
            far_ff[k]  <= far_ff[k-1];
         end
         // stage 1: edges and origin offset
         for (int k = 0; k < 3; k++) begin
            d1_ff[k]  <= coord(req_ray_direction, k);
            t1_ff[k]  <= coord(req_ray_origin, k) - coord(req_vertex_a, k);
            e11_ff[k] <= coord(req_vertex_b, k) - coord(req_vertex_a, k);
            e21_ff[k] <= coord(req_vertex_c, k) - coord(req_vertex_a, k);
         end
         // stage 2: cross product terms
         for (int k = 0; k < 3; k++) begin
            mp_ff[2*k]   <= d1_ff[nx(k)] * e21_ff[nx(nx(k))];
            mp_ff[2*k+1] <= d1_ff[nx(nx(k))] * e21_ff[nx(k)];
            mq_ff[2*k]   <= t1_ff[nx(k)] * e11_ff[nx(nx(k))];
            mq_ff[2*k+1] <= t1_ff[nx(nx(k))] * e11_ff[nx(k)];
            d2_ff[k] <= d1_ff[k];  t2_ff[k] <= t1_ff[k];
            e12_ff[k] <= e11_ff[k];  e22_ff[k] <= e21_ff[k];
         end
         // stage 3: cross products p = d x e2, q = t x e1
         for (int k = 0; k < 3; k++) begin
            p_ff[k] <= PW'(mp_ff[2*k]) - PW'(mp_ff[2*k+1]);
            q_ff[k] <= PW'(mq_ff[2*k]) - PW'(mq_ff[2*k+1]);
            d3_ff[k] <= d2_ff[k];  t3_ff[k] <= t2_ff[k];
            e13_ff[k] <= e12_ff[k];  e23_ff[k] <= e22_ff[k];
         end
         // stage 4: split multiplies, high and low slices of the wide operand
         for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
               phi_ff[i][k] <= opa[i][k] * $signed(opb[i][k][PW-1:LW]);
               plo_ff[i][k] <= opa[i][k] * $signed({1'b0, opb[i][k][LW-1:0]});
            end
         end
         // stage 5: dot products
         for (int i = 0; i < 4; i++) begin
            dot_ff[i] <= dot_in[i];
         end
         // stage 6: make det positive
         zero_ff <= dot_ff[0] == '0;
         for (int i = 0; i < 4; i++) begin
            nrm_ff[i] <= dot_ff[0][DW-1] ? DW'(-dot_ff[i]) : dot_ff[i];
         end
         // stage 7: classified job
         job_ff <= job_in;
      end
   end

endmodule

>>> hw/rtl/rti_fifo.sv
// Short first-word-fall-through queue between front and back.
// Depends on rti_pkg for the job type and depth.
`timescale 1ns / 1ps

module rti_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rti_pkg::job_type  wr_data,
   input  logic              pop,
   output rti_pkg::job_type  rd_data,
   output logic              full,
   output logic              empty
);

   localparam int AW = rti_pkg::FIFO_AW;

   rti_pkg::job_type mem_ff [rti_pkg::FIFO_DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW:0]      cnt_ff;
   logic [AW:0]      cnt_in;

   assign full    = cnt_ff == (AW+1)'(rti_pkg::FIFO_DEPTH);
   assign empty   = cnt_ff == '0;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign cnt_in  = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/rti_back.sv
// Back pipeline: three dividers for t, u, v, then saturation, interval
// test and the output register. Depends on rti_pkg, rti_div, assert macros.
`timescale 1ns / 1ps
`include "ray_triangle_intersect_assert.svh"

module rti_back (
   input  logic                              clock,
   input  logic                              reset,
   input  rti_pkg::job_type                  job,
   input  logic                              fifo_empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic signed [rti_pkg::LIM_W-1:0]  rsp_distance,
   output logic [rti_pkg::BARY_W-1:0]        rsp_bary_u,
   output logic [rti_pkg::BARY_W-1:0]        rsp_bary_v
);

   localparam int QB = rti_pkg::QB;
   localparam int LW = rti_pkg::LIM_W;
   localparam int BW = rti_pkg::BARY_W;

   typedef struct packed {
      logic                 miss;
      logic                 tneg;
      logic                 ovf;
      logic signed [LW-1:0] near_lim;
      logic signed [LW-1:0] far_lim;
   } side_type;

   logic               be_en;
   logic [QB-1:0]      vld_ff;
   side_type           sb_ff [QB];
   side_type           sb_last;
   logic [QB-1:0]      qt, qu, qv;
   logic               rt_nz, ru_nz, rv_nz;
   logic signed [LW-1:0] t_val;
   logic               hit_in;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic               rsp_hit_in;
   logic signed [LW-1:0] rsp_dist_ff;
   logic signed [LW-1:0] rsp_dist_in;
   logic [BW-1:0]      rsp_u_ff, rsp_u_in;
   logic [BW-1:0]      rsp_v_ff, rsp_v_in;

   assign be_en = !rsp_valid_ff || rsp_ready;
   assign pop   = be_en && !fifo_empty;

   rti_div u_div_t (.clock(clock), .en(be_en), .num(job.mag), .den(job.det),
                    .quo(qt), .rem_nz(rt_nz));
   rti_div u_div_u (.clock(clock), .en(be_en), .num(job.un), .den(job.det),
                    .quo(qu), .rem_nz(ru_nz));
   rti_div u_div_v (.clock(clock), .en(be_en), .num(job.vn), .den(job.det),
                    .quo(qv), .rem_nz(rv_nz));

   // beat valid and side data alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (be_en) begin
         vld_ff <= {vld_ff[QB-2:0], !fifo_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (be_en) begin
         sb_ff[0] <= '{miss: job.miss, tneg: job.tneg, ovf: job.ovf,
                       near_lim: job.near_lim, far_lim: job.far_lim};
         for (int k = 1; k < QB; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   assign sb_last = sb_ff[QB-1];

   // signed distance with saturation, rounded toward minus infinity
   always_comb begin
      if (!sb_last.tneg) begin
         t_val = sb_last.ovf ? {1'b0, {(LW-1){1'b1}}} : $signed({1'b0, qt});
      end else if (sb_last.ovf) begin
         t_val = {1'b1, {(LW-1){1'b0}}};
      end else begin
         t_val = $signed(LW'(0) - ({1'b0, qt} + LW'(rt_nz)));
      end
      hit_in      = !sb_last.miss && !(t_val < sb_last.near_lim)
                    && !(t_val > sb_last.far_lim);
      rsp_hit_in  = hit_in;
      rsp_dist_in = hit_in ? t_val : '0;
      rsp_u_in    = hit_in ? qu[BW-1:0] : '0;
      rsp_v_in    = hit_in ? qv[BW-1:0] : '0;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (be_en) begin
         rsp_valid_ff <= vld_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (be_en) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_dist_ff <= rsp_dist_in;
         rsp_u_ff    <= rsp_u_in;
         rsp_v_ff    <= rsp_v_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_bary_u   = rsp_u_ff;
   assign rsp_bary_v   = rsp_v_ff;

   // unused remainder flags of the barycentric divides
   logic unused_rem;
   assign unused_rem = ru_nz ^ rv_nz;

   `RTI_ASSERT_IMPLY(a_miss_zero, rsp_valid_ff && !rsp_hit_ff,
      rsp_dist_ff == '0 && rsp_u_ff == '0 && rsp_v_ff == '0)
   `RTI_ASSERT_IMPLY(a_bary_sum, rsp_valid_ff && rsp_hit_ff,
      ({1'b0, rsp_u_ff} + {1'b0, rsp_v_ff}) <= (BW+1)'(1 << rti_pkg::SCALE))
   `RTI_ASSERT_NEXT(a_pop_enters, pop, vld_ff[0])

endmodule

>>> hw/rtl/ray_triangle_intersect.sv
// Ray/triangle intersection, top level.
// Use: one ray and one triangle per req beat (valid/ready); one result per
//  rsp beat (valid/ready) carrying hit, Q16.16 distance and Q1.16 u, v,
//  all zero on a miss. The csr port writes the determinant epsilon; write
//  it only while no beat is in flight.
// Pipeline: 7 front stages (edges, cross products, split multiplies, dot
//  sums, sign fix, classification), one pass through the job queue, 31
//  divider stages (one quotient bit each) and the output register.
// Throughput: one beat per cycle unless stalled; the 31-stage t, u and v
//  dividers run in parallel and each accepts an operand pair per unstalled cycle.
// Stall: the back stalls only while rsp_valid is high and rsp_ready low;
//  the four-entry job queue absorbs the front meanwhile, and req_ready
//  drops once that queue is full.
// Reset (synchronous, active high) empties every pipeline stage and the
//  queue and returns the epsilon register to 1074.
// Depends on rti_pkg, rti_front, rti_fifo, rti_back, rti_div.
`timescale 1ns / 1ps

module ray_triangle_intersect (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rti_pkg::EPS_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rti_pkg::IN_W-1:0]          req_ray_origin,
   input  logic [rti_pkg::IN_W-1:0]          req_ray_direction,
   input  logic [rti_pkg::IN_W-1:0]          req_vertex_a,
   input  logic [rti_pkg::IN_W-1:0]          req_vertex_b,
   input  logic [rti_pkg::IN_W-1:0]          req_vertex_c,
   input  logic signed [rti_pkg::LIM_W-1:0]  req_near_limit,
   input  logic signed [rti_pkg::LIM_W-1:0]  req_far_limit,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic signed [rti_pkg::LIM_W-1:0]  rsp_distance,
   output logic [rti_pkg::BARY_W-1:0]        rsp_bary_u,
   output logic [rti_pkg::BARY_W-1:0]        rsp_bary_v
);

   logic             push;
   logic             pop;
   logic             fifo_full;
   logic             fifo_empty;
   rti_pkg::job_type front_job;
   rti_pkg::job_type back_job;

   rti_front u_front (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ray_origin(req_ray_origin), .req_ray_direction(req_ray_direction),
      .req_vertex_a(req_vertex_a), .req_vertex_b(req_vertex_b),
      .req_vertex_c(req_vertex_c),
      .req_near_limit(req_near_limit), .req_far_limit(req_far_limit),
      .fifo_full(fifo_full), .push(push), .job(front_job)
   );

   rti_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .wr_data(front_job),
      .pop(pop), .rd_data(back_job),
      .full(fifo_full), .empty(fifo_empty)
   );

   rti_back u_back (
      .clock(clock), .reset(reset),
      .job(back_job), .fifo_empty(fifo_empty), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_distance(rsp_distance),
      .rsp_bary_u(rsp_bary_u), .rsp_bary_v(rsp_bary_v)
   );

endmodule

>>> test/ray_triangle_intersect_test.sv
// Self-checking bench for ray_triangle_intersect: a directed stimulus table, then
// random ray/triangle beats checked against an exact fixed-point intersection model.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
`timescale 1ns / 1ps

module ray_triangle_intersect_test;

   localparam int CW     = rti_pkg::CW;
   localparam int IN_W   = rti_pkg::IN_W;
   localparam int EPS_W  = rti_pkg::EPS_W;
   localparam int LIM_W  = rti_pkg::LIM_W;
   localparam int BARY_W = rti_pkg::BARY_W;
   localparam logic [EPS_W-1:0] EPS_RESET = rti_pkg::EPS_RESET;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic                    hit;
      logic signed [LIM_W-1:0] distance;
      logic [BARY_W-1:0]       u;
      logic [BARY_W-1:0]       v;
   } hit_result_type;

   typedef struct {
      logic [IN_W-1:0]         origin, direction, va, vb, vc;
      logic signed [LIM_W-1:0] near_lim, far_lim;
      bit                      typed;
      hit_result_type          want;
   } tri_case_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int ONE            = 1024;    // 1.0 in Q10.10
   localparam logic signed [LIM_W-1:0] LIM_MIN = 32'sh8000_0000;
   localparam logic signed [LIM_W-1:0] LIM_MAX = 32'sh7FFF_FFFF;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [EPS_W-1:0]        csr_wr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [IN_W-1:0]         req_ray_origin = '0, req_ray_direction = '0;
   logic [IN_W-1:0]         req_vertex_a = '0, req_vertex_b = '0, req_vertex_c = '0;
   logic signed [LIM_W-1:0] req_near_limit = '0, req_far_limit = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_hit;
   logic signed [LIM_W-1:0] rsp_distance;
   logic [BARY_W-1:0]       rsp_bary_u, rsp_bary_v;

   logic [EPS_W-1:0] model_eps = EPS_RESET;
   hit_result_type   pending_hits[$];
   tri_case_type     stim_rows[$];
   int               errors = 0;
   bit               calm = 1'b0;   // no idling on either side
   int               sink_hold = 0;
   int               idle_cycles = 0;

   ray_triangle_intersect i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ray_origin(req_ray_origin), .req_ray_direction(req_ray_direction),
      .req_vertex_a(req_vertex_a), .req_vertex_b(req_vertex_b),
      .req_vertex_c(req_vertex_c),
      .req_near_limit(req_near_limit), .req_far_limit(req_far_limit),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_distance(rsp_distance), .rsp_bary_u(rsp_bary_u), .rsp_bary_v(rsp_bary_v)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [IN_W-1:0] pack3(int x, int y, int z);
      return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
   endfunction

   function automatic void cross3(input longint a[3], input longint b[3],
                                  output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic wide_type dot3(input longint a[3], input longint b[3]);
      wide_type s;
      s = 0;
      for (int k = 0; k < 3; k++) s += wide_type'(a[k]) * wide_type'(b[k]);
      return s;
   endfunction

   // exact Moller-Trumbore on the numerators, one floor division per output
   function automatic hit_result_type intersect_model(tri_case_type tc);
      longint o[3], d[3], a[3], b[3], c[3], e1[3], e2[3], tv[3], pv[3], qv[3];
      wide_type det, un, vn, tn, mag, q, r;
      longint t;
      hit_result_type res;
      res = '{1'b0, '0, '0, '0};
      for (int k = 0; k < 3; k++) begin
         o[k] = $signed(tc.origin[k*CW +: CW]);
         d[k] = $signed(tc.direction[k*CW +: CW]);
         a[k] = $signed(tc.va[k*CW +: CW]);
         b[k] = $signed(tc.vb[k*CW +: CW]);
         c[k] = $signed(tc.vc[k*CW +: CW]);
         e1[k] = b[k] - a[k];
         e2[k] = c[k] - a[k];
         tv[k] = o[k] - a[k];
      end
      cross3(d, e2, pv);
      cross3(tv, e1, qv);
      det = dot3(e1, pv);
      un  = dot3(tv, pv);
      vn  = dot3(d, qv);
      tn  = dot3(e2, qv);
      // parallel ray
      if (det == 0) return res;
      if (det < 0) begin
         det = -det; un = -un; vn = -vn; tn = -tn;
      end
      if (det < wide_type'(model_eps)) return res;
      // outside the triangle
      if (un < 0 || un > det || vn < 0 || un + vn > det) return res;
      mag = (tn < 0) ? -tn : tn;
      q = (mag <<< 16) / det;
      r = (mag <<< 16) % det;
      if (tn >= 0) t = (q > 128'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
      else if (q >= 128'sh8000_0000) t = -64'sh8000_0000;
      else t = -(longint'(q) + ((r != 0) ? 1 : 0));
      if (t < longint'(tc.near_lim) || t > longint'(tc.far_lim)) return res;
      res.hit = 1'b1;
      res.distance = t[LIM_W-1:0];
      q = (un <<< 16) / det;
      res.u = q[BARY_W-1:0];
      q = (vn <<< 16) / det;
      res.v = q[BARY_W-1:0];
      return res;
   endfunction

   function automatic tri_case_type make_row(logic [IN_W-1:0] o, dir, va, vb, vc,
                                             logic signed [LIM_W-1:0] nl, fl,
                                             bit typed = 0, logic h = 0,
                                             logic signed [LIM_W-1:0] want_dist = 0,
                                             logic [BARY_W-1:0] u = 0, v = 0);
      tri_case_type tc;
      tc.origin = o; tc.direction = dir; tc.va = va; tc.vb = vb; tc.vc = vc;
      tc.near_lim = nl; tc.far_lim = fl; tc.typed = typed;
      tc.want = '{h, want_dist, u, v};
      return tc;
   endfunction

   // random beat: mostly rays aimed into the triangle, the rest noise
   function automatic tri_case_type random_case();
      tri_case_type tc;
      int ax, ay, az, bx, by, bz, cx, cy, cz, ox, oy, oz, s, r, tx, ty, tz;
      int span;
      if ($urandom_range(0, 3) == 0) begin
         tc.origin    = {$urandom, $urandom};
         tc.direction = {$urandom, $urandom};
         tc.va = {$urandom, $urandom};
         tc.vb = {$urandom, $urandom};
         tc.vc = {$urandom, $urandom};
         tc.near_lim = $urandom;
         tc.far_lim  = $urandom;
      end else begin
         span = ($urandom_range(0, 3) == 0) ? 250000 : 8192;
         ax = $urandom_range(0, 2*span) - span; ay = $urandom_range(0, 2*span) - span;
         az = $urandom_range(0, 2*span) - span; bx = $urandom_range(0, 2*span) - span;
         by = $urandom_range(0, 2*span) - span; bz = $urandom_range(0, 2*span) - span;
         cx = $urandom_range(0, 2*span) - span; cy = $urandom_range(0, 2*span) - span;
         cz = $urandom_range(0, 2*span) - span;
         ox = $urandom_range(0, 2*span) - span; oy = $urandom_range(0, 2*span) - span;
         oz = $urandom_range(0, 2*span) - span;
         s = $urandom_range(0, 16);
         r = $urandom_range(0, 16 - s);
         tx = ax + ((bx - ax) * s + (cx - ax) * r) / 16;
         ty = ay + ((by - ay) * s + (cy - ay) * r) / 16;
         tz = az + ((bz - az) * s + (cz - az) * r) / 16;
         tc.origin    = pack3(ox, oy, oz);
         tc.direction = ($urandom_range(0, 1)) ? pack3(tx - ox, ty - oy, tz - oz)
                                              : pack3((tx - ox) / 4, (ty - oy) / 4,
                                                      (tz - oz) / 4);
         tc.va = pack3(ax, ay, az);
         tc.vb = pack3(bx, by, bz);
         tc.vc = pack3(cx, cy, cz);
         case ($urandom_range(0, 4))
            0: begin tc.near_lim = $urandom; tc.far_lim = $urandom; end
            1: begin tc.near_lim = 0; tc.far_lim = 32'sh0001_0000; end
            default: begin tc.near_lim = LIM_MIN; tc.far_lim = LIM_MAX; end
         endcase
      end
      tc.typed = 0;
      return tc;
   endfunction

   task automatic csr_write(logic [EPS_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_eps = value;
   endtask

   // hold the beat until accepted; optional gap before it
   task automatic send_beat(tri_case_type tc);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_ray_origin    <= tc.origin;
      req_ray_direction <= tc.direction;
      req_vertex_a      <= tc.va;
      req_vertex_b      <= tc.vb;
      req_vertex_c      <= tc.vc;
      req_near_limit    <= tc.near_lim;
      req_far_limit     <= tc.far_lim;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_hits.push_back(tc.typed ? tc.want : intersect_model(tc));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result sink with random stall bursts
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         sink_hold <= $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      hit_result_type exp_hit;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected result beat hit=%0b", $time, rsp_hit);
            errors++;
         end else begin
            exp_hit = pending_hits.pop_front();
            if (rsp_hit !== exp_hit.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, exp_hit.hit, rsp_hit);
               errors++;
            end
            if (rsp_distance !== exp_hit.distance) begin
               $display("%0t: distance expected %0d actual %0d", $time,
                        exp_hit.distance, rsp_distance);
               errors++;
            end
            if (rsp_bary_u !== exp_hit.u) begin
               $display("%0t: bary_u expected %0d actual %0d", $time, exp_hit.u, rsp_bary_u);
               errors++;
            end
            if (rsp_bary_v !== exp_hit.v) begin
               $display("%0t: bary_v expected %0d actual %0d", $time, exp_hit.v, rsp_bary_v);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles without any beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      logic [EPS_W-1:0] eps_plan[4];
      logic [IN_W-1:0] tri_a, tri_b, tri_c, down;
      tri_a = pack3(0, 0, 0);
      tri_b = pack3(ONE, 0, 0);
      tri_c = pack3(0, ONE, 0);
      down  = pack3(0, 0, -ONE);
      // all zero: degenerate, det is zero
      stim_rows.push_back(make_row('0, '0, '0, '0, '0, 0, 0, 1, 0));
      // centered hit at distance 1.0, u = v = 0.25
      stim_rows.push_back(make_row(pack3(ONE/4, ONE/4, ONE), down, tri_a, tri_b, tri_c,
                                   0, LIM_MAX, 1, 1, 32'sh0001_0000, 17'd16384, 17'd16384));
      // same ray, far limit below the hit
      stim_rows.push_back(make_row(pack3(ONE/4, ONE/4, ONE), down, tri_a, tri_b, tri_c,
                                   0, 32'sh0000_FFFF, 1, 0));
      // inverted interval
      stim_rows.push_back(make_row(pack3(ONE/4, ONE/4, ONE), down, tri_a, tri_b, tri_c,
                                   LIM_MAX, LIM_MIN, 1, 0));
      // hit exactly on vertex B: u = 1, v = 0
      stim_rows.push_back(make_row(pack3(ONE, 0, ONE), down, tri_a, tri_b, tri_c,
                                   LIM_MIN, LIM_MAX, 1, 1, 32'sh0001_0000, 17'h10000, 0));
      // triangle behind the origin: negative distance
      stim_rows.push_back(make_row(pack3(ONE/4, ONE/4, -ONE), down, tri_a, tri_b, tri_c,
                                   LIM_MIN, LIM_MAX, 1, 1, -32'sh0001_0000, 17'd16384,
                                   17'd16384));
      // outside the triangle on u, on v, on u + v
      stim_rows.push_back(make_row(pack3(-ONE/4, ONE/4, ONE), down, tri_a, tri_b, tri_c,
                                   LIM_MIN, LIM_MAX));
      stim_rows.push_back(make_row(pack3(ONE/4, -ONE/4, ONE), down, tri_a, tri_b, tri_c,
                                   LIM_MIN, LIM_MAX));
      stim_rows.push_back(make_row(pack3(ONE*3/4, ONE*3/4, ONE), down, tri_a, tri_b, tri_c,
                                   LIM_MIN, LIM_MAX));
      // reversed winding: negative determinant
      stim_rows.push_back(make_row(pack3(ONE/4, ONE/4, ONE), down, tri_a, tri_c, tri_b,
                                   LIM_MIN, LIM_MAX));
      // tiny direction, far origin: distance saturates high and low
      stim_rows.push_back(make_row(pack3(ONE/4, ONE/4, 20'hFFFFF), pack3(0, 0, -1),
                                   tri_a, tri_b, tri_c, LIM_MIN, LIM_MAX));
      stim_rows.push_back(make_row(pack3(ONE/4, ONE/4, -20'hFFFFF), pack3(0, 0, -1),
                                   tri_a, tri_b, tri_c, LIM_MIN, LIM_MAX));
      // tiny determinant against the epsilon
      stim_rows.push_back(make_row(pack3(1, 1, 8), pack3(0, 0, -1), tri_a, pack3(16, 0, 0),
                                   pack3(0, 16, 0), LIM_MIN, LIM_MAX));
      // field extremes
      stim_rows.push_back(make_row('1, '1, '1, '1, '1, LIM_MIN, LIM_MAX));
      stim_rows.push_back(make_row(pack3(-(1<<20), -(1<<20), -(1<<20)),
                                   pack3((1<<20)-1, (1<<20)-1, (1<<20)-1),
                                   pack3(-(1<<20), (1<<20)-1, 0),
                                   pack3((1<<20)-1, -(1<<20), (1<<20)-1),
                                   pack3(0, 0, -(1<<20)), LIM_MIN, LIM_MAX));
      stim_rows.push_back(make_row(pack3((1<<20)-1, 0, -(1<<20)), pack3(-1, -1, -1),
                                   pack3(-(1<<20), -(1<<20), -(1<<20)),
                                   pack3((1<<20)-1, -(1<<20), (1<<20)-1),
                                   pack3(-(1<<20), (1<<20)-1, (1<<20)-1), 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset epsilon, then the untyped rows at the maximum epsilon
      foreach (stim_rows[i]) send_beat(stim_rows[i]);
      drain();
      csr_write(20'hFFFFF);
      foreach (stim_rows[i]) if (!stim_rows[i].typed) send_beat(stim_rows[i]);
      drain();

      eps_plan[0] = 20'd0;
      eps_plan[1] = $urandom_range(0, 20'hFFFFF);
      eps_plan[2] = 20'hFFFFF;
      eps_plan[3] = EPS_RESET;
      foreach (eps_plan[p]) begin
         csr_write(eps_plan[p]);
         calm = (p == 3);
         repeat (125) send_beat(random_case());
         drain();
      end

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
